FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the point-in-solid test block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every sampled edge
`define CHK_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/pia8_pkg.sv
// ----------------------------------------------------------------------------
// pia8_pkg
// shared widths, types and register indexes of the point-in-solid test
// ----------------------------------------------------------------------------
`default_nettype none

package pia8_pkg;

   localparam int CW      = 16;   // coordinate width
   localparam int DIV_MW  = 36;   // divider dividend width
   localparam int DIV_DW  = 18;   // divider divisor width
   localparam int DIV_QW  = 18;   // quotient bits, one pipeline stage each
   localparam int CSR_AW  = 6;

   typedef logic signed [CW-1:0] coord_type;

   typedef enum logic [2:0] {
      CSR_HALF_LEN = 3'd0,
      CSR_LO_A     = 3'd1,
      CSR_LO_B     = 3'd2,
      CSR_HI_A     = 3'd3,
      CSR_HI_B     = 3'd4
   } csr_idx_type;

   typedef struct packed {
      logic [14:0] half_len;
      logic [63:0] lo_a;
      logic [63:0] lo_b;
      logic [63:0] hi_a;
      logic [63:0] hi_b;
   } cfg_type;

   // interpolated cross-section handed to the scan-line stages
   typedef struct packed {
      logic                valid;
      logic                oor;
      coord_type           px;
      coord_type           py;
      coord_type [3:0]     qx;
      coord_type [3:0]     qy;
   } quad_type;

   typedef struct packed {
      logic       valid;
      logic       in_solid;
      logic [2:0] count;
   } res_type;

endpackage

`default_nettype wire

FILE: hdl/pia8_ifs.sv
// ----------------------------------------------------------------------------
// pia8_ifs
// request and response channels of the point-in-solid test
// ----------------------------------------------------------------------------
`default_nettype none

interface pia8_req_if;
   logic                valid;
   logic                ready;
   pia8_pkg::coord_type point_x;
   pia8_pkg::coord_type point_y;
   pia8_pkg::coord_type point_z;
   modport source (output valid, output point_x, output point_y, output point_z,
                   input ready);
   modport sink   (input valid, input point_x, input point_y, input point_z,
                   output ready);
endinterface

interface pia8_rsp_if;
   logic       valid;
   logic       ready;
   logic       inside_res;
   logic [2:0] crossing_count;
   modport source (output valid, output inside_res, output crossing_count, input ready);
   modport sink   (input valid, input inside_res, input crossing_count, output ready);
endinterface

`default_nettype wire

FILE: hdl/pia8_div.sv
// ----------------------------------------------------------------------------
// pia8_div
// pipelined restoring divider lane, one quotient bit per stage, floor result
// ----------------------------------------------------------------------------
`default_nettype none

module pia8_div (
   input  logic                               clock,
   input  logic                               adv,
   input  logic [pia8_pkg::DIV_MW-1:0]        m,
   input  logic [pia8_pkg::DIV_DW-1:0]        d,
   input  logic                               neg,
   output logic signed [pia8_pkg::DIV_QW:0]   q
);
   localparam int MW = pia8_pkg::DIV_MW;
   localparam int DW = pia8_pkg::DIV_DW;
   localparam int QW = pia8_pkg::DIV_QW;

   logic [MW-1:0] rem_ff [QW];
   logic [DW-1:0] d_ff   [QW];
   logic [QW-1:0] q_ff   [QW];
   logic          neg_ff [QW];

   for (genvar s = 0; s < QW; s++) begin : g_stage
      logic [MW-1:0] rem_prev;
      logic [DW-1:0] d_prev;
      logic [QW-1:0] q_prev;
      logic          neg_prev;
      logic [MW-1:0] shd;
      logic          take;

      if (s == 0) begin : g_first
         assign rem_prev = m;
         assign d_prev   = d;
         assign q_prev   = '0;
         assign neg_prev = neg;
      end else begin : g_next
         assign rem_prev = rem_ff[s-1];
         assign d_prev   = d_ff[s-1];
         assign q_prev   = q_ff[s-1];
         assign neg_prev = neg_ff[s-1];
      end

      // divisor aligned to this stage's quotient bit
      assign shd  = MW'(d_prev) << (QW - 1 - s);
      assign take = rem_prev >= shd;

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[s] <= take ? (rem_prev - shd) : rem_prev;
            d_ff[s]   <= d_prev;
            q_ff[s]   <= {q_prev[QW-2:0], take};
            neg_ff[s] <= neg_prev;
         end
      end
   end

   // negative dividends were folded as ~n, so floor(n/d) = ~floor(~n/d)
   assign q = neg_ff[QW-1] ? signed'(~{1'b0, q_ff[QW-1]}) : signed'({1'b0, q_ff[QW-1]});

endmodule

`default_nettype wire

FILE: hdl/pia8_quad.sv
// ----------------------------------------------------------------------------
// pia8_quad
// z range check and interpolation of the four side edges to the point's z
// ----------------------------------------------------------------------------
`default_nettype none

module pia8_quad (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_valid,
   input  pia8_pkg::coord_type  in_x,
   input  pia8_pkg::coord_type  in_y,
   input  pia8_pkg::coord_type  in_z,
   input  pia8_pkg::cfg_type    cfg,
   output pia8_pkg::quad_type   quad
);
   localparam int CW = pia8_pkg::CW;
   localparam int MW = pia8_pkg::DIV_MW;
   localparam int DW = pia8_pkg::DIV_DW;
   localparam int QW = pia8_pkg::DIV_QW;

   typedef struct packed {
      logic                          oor;
      pia8_pkg::coord_type           px;
      pia8_pkg::coord_type           py;
      pia8_pkg::coord_type [7:0]     hi;
   } side_type;

   // stage 0: accepted request
   logic                 s0_valid_ff;
   pia8_pkg::coord_type  s0_x_ff, s0_y_ff, s0_z_ff;

   // stage 1: differences
   logic                 s1_valid_ff;
   side_type             s1_side_ff, s1_side_in;
   logic signed [17:0]   s1_dzp_ff, s1_dzp_in;
   logic signed [16:0]   s1_d_ff [8];
   logic signed [16:0]   s1_d_in [8];

   // stage 2: products
   logic                 s2_valid_ff;
   side_type             s2_side_ff;
   logic signed [34:0]   s2_num_ff [8];

   // stage 3: folded dividends
   logic                 s3_valid_ff;
   side_type             s3_side_ff;
   logic [MW-1:0]        s3_m_ff [8];
   logic [MW-1:0]        s3_m_in [8];
   logic                 s3_neg_ff [8];
   logic                 s3_neg_in [8];

   // divider side band
   logic                 dv_valid_ff [QW];
   side_type             dv_side_ff  [QW];
   logic signed [QW:0]   quo [8];

   pia8_pkg::coord_type  hi_in [8];
   pia8_pkg::coord_type  vert_in [8];
   pia8_pkg::quad_type   quad_ff, quad_in;

   logic signed [17:0]   dz, pz;
   logic [DW-1:0]        div_d;

   assign dz    = signed'({3'b000, cfg.half_len});
   assign pz    = 18'(s0_z_ff);
   assign div_d = DW'({cfg.half_len, 2'b00});

   for (genvar i = 0; i < 4; i++) begin : g_vert
      localparam int SX = (i % 2) * 2 * CW;
      logic [63:0]         lo_reg, hi_reg;
      pia8_pkg::coord_type lx, ly, hx, hy;
      assign lo_reg = (i < 2) ? cfg.lo_a : cfg.lo_b;
      assign hi_reg = (i < 2) ? cfg.hi_a : cfg.hi_b;
      assign lx = lo_reg[SX +: CW];
      assign ly = lo_reg[SX + CW +: CW];
      assign hx = hi_reg[SX +: CW];
      assign hy = hi_reg[SX + CW +: CW];
      assign s1_d_in[2*i]   = 17'(lx) - 17'(hx);
      assign s1_d_in[2*i+1] = 17'(ly) - 17'(hy);
      assign hi_in[2*i]     = hx;
      assign hi_in[2*i+1]   = hy;
   end

   always_comb begin
      s1_side_in.oor = (cfg.half_len == '0) || (pz > dz) || (pz < -dz);
      s1_side_in.px  = s0_x_ff;
      s1_side_in.py  = s0_y_ff;
      for (int j = 0; j < 8; j++) begin
         s1_side_in.hi[j] = hi_in[j];
      end
      s1_dzp_in = dz - pz;
   end

   // round(num / 2dz) folded as floor((2num + 2dz) / 4dz)
   for (genvar j = 0; j < 8; j++) begin : g_fold
      logic [36:0] nsum;
      assign nsum = (37'(s2_num_ff[j]) <<< 1) + 37'({cfg.half_len, 1'b0});
      assign s3_neg_in[j] = nsum[36];
      assign s3_m_in[j]   = s3_neg_in[j] ? MW'(~nsum) : MW'(nsum);

      pia8_div u_div (
         .clock (clock),
         .adv   (adv),
         .m     (s3_m_ff[j]),
         .d     (div_d),
         .neg   (s3_neg_ff[j]),
         .q     (quo[j])
      );

      assign vert_in[j] = CW'(19'(dv_side_ff[QW-1].hi[j]) + quo[j]);
   end

   always_comb begin
      quad_in.valid = dv_valid_ff[QW-1];
      quad_in.oor   = dv_side_ff[QW-1].oor;
      quad_in.px    = dv_side_ff[QW-1].px;
      quad_in.py    = dv_side_ff[QW-1].py;
      for (int i = 0; i < 4; i++) begin
         quad_in.qx[i] = vert_in[2*i];
         quad_in.qy[i] = vert_in[2*i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff    <= 1'b0;
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         s3_valid_ff    <= 1'b0;
         for (int s = 0; s < QW; s++) begin
            dv_valid_ff[s] <= 1'b0;
         end
      end else if (adv) begin
         s0_valid_ff    <= in_valid;
         s1_valid_ff    <= s0_valid_ff;
         s2_valid_ff    <= s1_valid_ff;
         s3_valid_ff    <= s2_valid_ff;
         dv_valid_ff[0] <= s3_valid_ff;
         for (int s = 1; s < QW; s++) begin
            dv_valid_ff[s] <= dv_valid_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_x_ff       <= in_x;
         s0_y_ff       <= in_y;
         s0_z_ff       <= in_z;
         s1_side_ff    <= s1_side_in;
         s1_dzp_ff     <= s1_dzp_in;
         s2_side_ff    <= s1_side_ff;
         s3_side_ff    <= s2_side_ff;
         dv_side_ff[0] <= s3_side_ff;
         for (int s = 1; s < QW; s++) begin
            dv_side_ff[s] <= dv_side_ff[s-1];
         end
         for (int j = 0; j < 8; j++) begin
            s1_d_ff[j]   <= s1_d_in[j];
            s2_num_ff[j] <= 35'(s1_dzp_ff) * 35'(s1_d_ff[j]);
            s3_m_ff[j]   <= s3_m_in[j];
            s3_neg_ff[j] <= s3_neg_in[j];
         end
      end
   end

   // output register, valid cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         quad_ff.valid <= 1'b0;
      end else if (adv) begin
         quad_ff       <= quad_in;
      end
   end

   assign quad = quad_ff;

endmodule

`default_nettype wire

FILE: hdl/pia8_cross.sv
// ----------------------------------------------------------------------------
// pia8_cross
// scan-line crossings of the cross-section edges and the inside decision
// ----------------------------------------------------------------------------
`default_nettype none

module pia8_cross (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  pia8_pkg::quad_type  quad,
   output pia8_pkg::res_type   res
);
   localparam int CW = pia8_pkg::CW;
   localparam int MW = pia8_pkg::DIV_MW;
   localparam int DW = pia8_pkg::DIV_DW;
   localparam int QW = pia8_pkg::DIV_QW;

   typedef struct packed {
      logic                       oor;
      pia8_pkg::coord_type        px;
      pia8_pkg::coord_type [3:0]  x1;
      logic [3:0]                 skip;
      logic [3:0]                 horiz;
      logic [3:0]                 hin;
   } side_type;

   logic                 e1_valid_ff;
   side_type             e1_side_ff, e1_side_in;
   logic signed [16:0]   e1_dy_ff [4];
   logic signed [16:0]   e1_dy_in [4];
   logic signed [16:0]   e1_dx_ff [4];
   logic signed [16:0]   e1_dx_in [4];
   logic signed [16:0]   e1_den_ff [4];
   logic signed [16:0]   e1_den_in [4];

   logic                 e2_valid_ff;
   side_type             e2_side_ff;
   logic signed [33:0]   e2_num_ff [4];
   logic signed [16:0]   e2_den_ff [4];

   logic                 e3_valid_ff;
   side_type             e3_side_ff;
   logic [MW-1:0]        e3_m_ff [4];
   logic [MW-1:0]        e3_m_in [4];
   logic [DW-1:0]        e3_d_ff [4];
   logic [DW-1:0]        e3_d_in [4];
   logic                 e3_neg_ff [4];
   logic                 e3_neg_in [4];

   logic                 dv_valid_ff [QW];
   side_type             dv_side_ff  [QW];
   logic signed [QW:0]   quo [4];

   logic                 e4_valid_ff;
   side_type             e4_side_ff;
   logic [3:0]           e4_lt_ff, e4_lt_in, e4_le_ff, e4_le_in;

   pia8_pkg::res_type    res_ff, res_in;

   logic [3:0]           skip_in, horiz_in, hin_in;
   pia8_pkg::coord_type  x1_in [4];

   for (genvar i = 0; i < 4; i++) begin : g_edge
      localparam int K = (i + 1) % 4;
      pia8_pkg::coord_type x1, y1, x2, y2, mn, mx;
      logic signed [16:0]  dy2;
      logic                dy1_pos, dy1_neg, dy2_pos, dy2_neg;

      assign x1 = quad.qx[i];
      assign y1 = quad.qy[i];
      assign x2 = quad.qx[K];
      assign y2 = quad.qy[K];

      assign e1_dy_in[i]  = 17'(quad.py) - 17'(y1);
      assign dy2          = 17'(y2) - 17'(quad.py);
      assign e1_dx_in[i]  = 17'(x2) - 17'(x1);
      assign e1_den_in[i] = 17'(y2) - 17'(y1);

      assign dy1_neg = e1_dy_in[i][16];
      assign dy1_pos = !e1_dy_in[i][16] && (e1_dy_in[i] != '0);
      assign dy2_neg = dy2[16];
      assign dy2_pos = !dy2[16] && (dy2 != '0);

      // edge does not reach the scan line
      assign skip_in[i]  = (dy1_neg && dy2_pos) || (dy1_pos && dy2_neg);
      assign horiz_in[i] = (y1 == y2);
      assign mn          = (x1 < x2) ? x1 : x2;
      assign mx          = (x1 < x2) ? x2 : x1;
      assign hin_in[i]   = (quad.px >= mn) && (quad.px <= mx);
      assign x1_in[i]    = x1;
   end

   always_comb begin
      e1_side_in.oor   = quad.oor;
      e1_side_in.px    = quad.px;
      e1_side_in.skip  = skip_in;
      e1_side_in.horiz = horiz_in;
      e1_side_in.hin   = hin_in;
      for (int i = 0; i < 4; i++) begin
         e1_side_in.x1[i] = x1_in[i];
      end
   end

   for (genvar i = 0; i < 4; i++) begin : g_lane
      logic                flip;
      logic signed [34:0]  numf;
      logic signed [17:0]  denf;
      logic [36:0]         nsum;
      pia8_pkg::coord_type seg;

      // make the denominator positive, then fold as in the vertex stage
      assign flip = e2_den_ff[i][16];
      assign numf = flip ? -35'(e2_num_ff[i]) : 35'(e2_num_ff[i]);
      assign denf = flip ? -18'(e2_den_ff[i]) : 18'(e2_den_ff[i]);
      assign nsum = (37'(numf) <<< 1) + 37'(denf);
      assign e3_neg_in[i] = nsum[36];
      assign e3_m_in[i]   = e3_neg_in[i] ? MW'(~nsum) : MW'(nsum);
      assign e3_d_in[i]   = DW'({denf, 1'b0});

      pia8_div u_div (
         .clock (clock),
         .adv   (adv),
         .m     (e3_m_ff[i]),
         .d     (e3_d_ff[i]),
         .neg   (e3_neg_ff[i]),
         .q     (quo[i])
      );

      assign seg         = CW'(19'(dv_side_ff[QW-1].x1[i]) + quo[i]);
      assign e4_lt_in[i] = seg <  dv_side_ff[QW-1].px;
      assign e4_le_in[i] = seg <= dv_side_ff[QW-1].px;
   end

   // walk edges in order; a horizontal edge on the line ends the walk.
   // with sorted crossings s, px lies in [s(k), s(k+1)] when at least k+1
   // are <= px and at most k+1 are < px
   always_comb begin
      logic       stop;
      logic       hsel;
      logic [2:0] n, a, b;
      logic       in_pair;
      stop = 1'b0;
      hsel = 1'b0;
      n    = '0;
      a    = '0;
      b    = '0;
      for (int i = 0; i < 4; i++) begin
         if (!stop && !e4_side_ff.skip[i]) begin
            if (e4_side_ff.horiz[i]) begin
               stop = 1'b1;
               hsel = e4_side_ff.hin[i];
            end else begin
               n = n + 3'd1;
               a = a + 3'(e4_lt_ff[i]);
               b = b + 3'(e4_le_ff[i]);
            end
         end
      end
      in_pair = ((n == 3'd2) || (n == 3'd4)) && (b >= 3'd1) && (a <= 3'd1);
      res_in.valid = e4_valid_ff;
      if (e4_side_ff.oor) begin
         res_in.in_solid = 1'b0;
         res_in.count    = '0;
      end else if (stop) begin
         res_in.in_solid = hsel;
         res_in.count    = n;
      end else begin
         res_in.in_solid = in_pair ||
                           ((n == 3'd4) && (b >= 3'd3) && (a <= 3'd3));
         res_in.count    = n;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_valid_ff  <= 1'b0;
         e2_valid_ff  <= 1'b0;
         e3_valid_ff  <= 1'b0;
         e4_valid_ff  <= 1'b0;
         for (int s = 0; s < QW; s++) begin
            dv_valid_ff[s] <= 1'b0;
         end
      end else if (adv) begin
         e1_valid_ff    <= quad.valid;
         e2_valid_ff    <= e1_valid_ff;
         e3_valid_ff    <= e2_valid_ff;
         dv_valid_ff[0] <= e3_valid_ff;
         for (int s = 1; s < QW; s++) begin
            dv_valid_ff[s] <= dv_valid_ff[s-1];
         end
         e4_valid_ff    <= dv_valid_ff[QW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e1_side_ff    <= e1_side_in;
         e2_side_ff    <= e1_side_ff;
         e3_side_ff    <= e2_side_ff;
         dv_side_ff[0] <= e3_side_ff;
         for (int s = 1; s < QW; s++) begin
            dv_side_ff[s] <= dv_side_ff[s-1];
         end
         e4_side_ff    <= dv_side_ff[QW-1];
         for (int i = 0; i < 4; i++) begin
            e1_dy_ff[i]  <= e1_dy_in[i];
            e1_dx_ff[i]  <= e1_dx_in[i];
            e1_den_ff[i] <= e1_den_in[i];
            e2_num_ff[i] <= 34'(e1_dy_ff[i]) * 34'(e1_dx_ff[i]);
            e2_den_ff[i] <= e1_den_ff[i];
            e3_m_ff[i]   <= e3_m_in[i];
            e3_d_ff[i]   <= e3_d_in[i];
            e3_neg_ff[i] <= e3_neg_in[i];
         end
         e4_lt_ff      <= e4_lt_in;
         e4_le_ff      <= e4_le_in;
      end
   end

   // result register, valid cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff.valid <= 1'b0;
      end else if (adv) begin
         res_ff       <= res_in;
      end
   end

   assign res = res_ff;

endmodule

`default_nettype wire

FILE: hdl/point_in_arb8_test.sv
// ----------------------------------------------------------------------------
// point_in_arb8_test
// inside/outside test of a 3-d point against an eight-vertex solid
// ----------------------------------------------------------------------------
// one point request per clock while the response buffer is not full, fully
// pipelined. a result reaches the response channel after its request has
// passed the two 18-stage divider pipelines (edge interpolation to the
// point's z, then the scan-line crossing x) plus their pre and post stages.
// the whole pipeline advances together and stops only when the two-entry
// response buffer is full, so one response may wait while requests keep
// flowing. no clearing pass after reset. solid registers sit on the apb port
// at 8-byte spacing and must be written while no requests are in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module point_in_arb8_test (
   input  logic                           clock,
   input  logic                           reset,
   pia8_req_if.sink                       req_ch,
   pia8_rsp_if.source                     rsp_ch,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [pia8_pkg::CSR_AW-1:0]    paddr,
   input  logic [63:0]                    pwdata,
   output logic [63:0]                    prdata,
   output logic                           pready
);

   // solid description registers
   pia8_pkg::cfg_type     cfg_ff;
   pia8_pkg::csr_idx_type csr_idx;
   logic                  csr_wr;

   // pipeline between the two halves
   pia8_pkg::quad_type    quad;
   pia8_pkg::res_type     res;

   // response buffer: head drives the port, skid catches one more
   logic [1:0]            cnt_ff, cnt_in;
   logic [3:0]            head_ff, head_in;
   logic [3:0]            skid_ff, skid_in;
   logic                  adv;
   logic                  push;
   logic                  pop;

   // ---------------- register port ----------------
   assign pready  = 1'b1;
   assign csr_idx = pia8_pkg::csr_idx_type'(paddr[pia8_pkg::CSR_AW-1:3]);
   assign csr_wr  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_len <= 15'd1;
         cfg_ff.lo_a     <= '0;
         cfg_ff.lo_b     <= '0;
         cfg_ff.hi_a     <= '0;
         cfg_ff.hi_b     <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            pia8_pkg::CSR_HALF_LEN: cfg_ff.half_len <= pwdata[14:0];
            pia8_pkg::CSR_LO_A:     cfg_ff.lo_a     <= pwdata;
            pia8_pkg::CSR_LO_B:     cfg_ff.lo_b     <= pwdata;
            pia8_pkg::CSR_HI_A:     cfg_ff.hi_a     <= pwdata;
            pia8_pkg::CSR_HI_B:     cfg_ff.hi_b     <= pwdata;
            default: begin
               // unmapped slot, write dropped
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         pia8_pkg::CSR_HALF_LEN: prdata = 64'(cfg_ff.half_len);
         pia8_pkg::CSR_LO_A:     prdata = cfg_ff.lo_a;
         pia8_pkg::CSR_LO_B:     prdata = cfg_ff.lo_b;
         pia8_pkg::CSR_HI_A:     prdata = cfg_ff.hi_a;
         pia8_pkg::CSR_HI_B:     prdata = cfg_ff.hi_b;
         default:                prdata = '0;
      endcase
   end

   // ---------------- pipeline ----------------
   // every stage moves on adv; it drops only when the buffer is full
   assign adv          = (cnt_ff != 2'd2);
   assign req_ch.ready = adv;

   // z check and side-edge interpolation
   pia8_quad u_quad (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (req_ch.valid),
      .in_x     (req_ch.point_x),
      .in_y     (req_ch.point_y),
      .in_z     (req_ch.point_z),
      .cfg      (cfg_ff),
      .quad     (quad)
   );

   // scan-line crossings and decision
   pia8_cross u_cross (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .quad  (quad),
      .res   (res)
   );

   // ---------------- response buffer ----------------
   assign push = res.valid && adv;
   assign pop  = rsp_ch.valid && rsp_ch.ready;

   always_comb begin
      cnt_in  = cnt_ff;
      head_in = head_ff;
      skid_in = skid_ff;
      case ({push, pop})
         2'b10: begin
            if (cnt_ff == 2'd0) begin
               head_in = {res.in_solid, res.count};
            end else begin
               skid_in = {res.in_solid, res.count};
            end
            cnt_in = cnt_ff + 2'd1;
         end
         2'b01: begin
            head_in = skid_ff;
            cnt_in  = cnt_ff - 2'd1;
         end
         2'b11: begin
            // one leaves, one arrives; buffer is never full here
            head_in = {res.in_solid, res.count};
         end
         default: begin
            // hold
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign rsp_ch.valid          = (cnt_ff != 2'd0);
   assign rsp_ch.inside_res     = head_ff[3];
   assign rsp_ch.crossing_count = head_ff[2:0];

endmodule

`default_nettype wire

FILE: hdl/pia8_checker.sv
// ----------------------------------------------------------------------------
// pia8_checker
// port-level checks of the point-in-solid test, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module pia8_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_inside,
   input logic [2:0] rsp_count
);

   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_inside) && $stable(rsp_count), "response changed while stalled")
   `CHK_ALWAYS(a_count_range, clock, reset, !rsp_valid || (rsp_count <= 3'd4), "crossing count above four")
   `CHK_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid && req_ready, "no empty ready state after reset")
   `CHK_ALWAYS(a_stall_cause, clock, reset, req_ready || rsp_valid || !req_valid, "request stalled with no response pending")

endmodule

bind point_in_arb8_test pia8_checker u_pia8_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_inside (rsp_ch.inside_res),
   .rsp_count  (rsp_ch.crossing_count)
);

`default_nettype wire
